/* design/sdn_pkg.sv */
// Shared widths, constants and types for the slice distance pipeline.
package sdn_pkg;

  localparam int PW = 32;           // position width
  localparam int CW = 16;           // direction cosine width
  localparam int DW = PW + 1;       // position difference width
  localparam int MW = 2 * CW;       // normal component magnitude width
  localparam int N2W = 2 * MW;      // squared length width
  localparam int LW = MW;           // integer square root width
  localparam int UNIT_BITS = 30;    // unit normal fraction bits
  localparam int QW = UNIT_BITS + 1;
  localparam int NUMW = MW + UNIT_BITS + 1;
  localparam int SPLIT = 17;        // low part of the difference for the multipliers
  localparam int TW = DW + QW + 3;  // exact dot product width

  typedef logic signed [DW-1:0] diff_t;
  typedef logic [2:0][MW-1:0] mag3_t;
  typedef logic [2:0][QW-1:0] q3_t;

  typedef struct packed {
    logic       rejected;
    logic       degenerate;
    logic [2:0] neg;
    diff_t      dx;
    diff_t      dy;
    diff_t      dz;
  } side_t;

endpackage

/* design/slice_distance_along_normal_top.sv */
// Top level of the slice distance along normal pipeline.
// Each slice transfer yields one result: the signed distance, in 1/1024 mm, of
// its corner from the stored reference corner along the unit normal row x col,
// rounded and saturated to 32 bits. The pipeline accepts one slice per cycle
// at sustained rate and is built from five front stages, one stage
// per bit of the 32-bit square root, one per bit of the 31-bit unit-component
// dividers and four dot-product stages. All stages advance together, so a stall
// on the result side holds the whole pipeline. A valid first slice loads the
// reference; an invalid slice returns zero with input_rejected set; a zero
// normal returns zero with degenerate_normal set, unless it is also rejected.
module slice_distance_along_normal_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               first_slice,
  input  logic               geometry_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] row_x,
  input  logic signed [15:0] row_y,
  input  logic signed [15:0] row_z,
  input  logic signed [15:0] col_x,
  input  logic signed [15:0] col_y,
  input  logic signed [15:0] col_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] distance,
  output logic               degenerate_normal,
  output logic               input_rejected
);
  import sdn_pkg::*;

  logic           adv;
  logic           f_valid, r_valid, q_valid;
  side_t          f_side, r_side, q_side;
  logic [N2W-1:0] f_n2;
  mag3_t          f_mag, r_mag;
  logic [LW-1:0]  r_len;
  q3_t            q_q;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  sdn_front u_front (
    .clk, .rst, .adv, .in_valid, .first_slice, .geometry_valid,
    .pos_x, .pos_y, .pos_z, .row_x, .row_y, .row_z, .col_x, .col_y, .col_z,
    .o_valid(f_valid), .o_side(f_side), .o_n2(f_n2), .o_mag(f_mag)
  );

  sdn_isqrt u_isqrt (
    .clk, .rst, .adv,
    .i_valid(f_valid), .i_side(f_side), .i_n2(f_n2), .i_mag(f_mag),
    .o_valid(r_valid), .o_side(r_side), .o_len(r_len), .o_mag(r_mag)
  );

  sdn_udiv u_udiv (
    .clk, .rst, .adv,
    .i_valid(r_valid), .i_side(r_side), .i_len(r_len), .i_mag(r_mag),
    .o_valid(q_valid), .o_side(q_side), .o_q(q_q)
  );

  sdn_dot u_dot (
    .clk, .rst, .adv,
    .i_valid(q_valid), .i_side(q_side), .i_q(q_q),
    .o_valid(out_valid), .distance, .degenerate_normal, .input_rejected
  );

endmodule

/* design/sdn_front.sv */
// Reference store, position difference, cross product and squared normal length.
module sdn_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic                       first_slice,
  input  logic                       geometry_valid,
  input  logic signed [31:0]         pos_x,
  input  logic signed [31:0]         pos_y,
  input  logic signed [31:0]         pos_z,
  input  logic signed [15:0]         row_x,
  input  logic signed [15:0]         row_y,
  input  logic signed [15:0]         row_z,
  input  logic signed [15:0]         col_x,
  input  logic signed [15:0]         col_y,
  input  logic signed [15:0]         col_z,
  output logic                       o_valid,
  output sdn_pkg::side_t             o_side,
  output logic [sdn_pkg::N2W-1:0]    o_n2,
  output sdn_pkg::mag3_t             o_mag
);
  import sdn_pkg::*;

  logic signed [PW-1:0] ref_x, ref_y, ref_z;
  logic                 load_ref;
  diff_t                dx_next, dy_next, dz_next;

  logic                 v0, v1, v2, v3;
  side_t                s0, s1, s2, s3;
  logic signed [CW-1:0] rx, ry, rz, cx, cy, cz;
  logic signed [2*CW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [2*CW:0] nx, ny, nz;
  mag3_t                mag2, mag3;
  logic [N2W-1:0]       sq0, sq1, sq2;

  assign load_ref = in_valid && adv && geometry_valid && first_slice;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
      ref_z <= '0;
    end else if (load_ref) begin
      ref_x <= pos_x;
      ref_y <= pos_y;
      ref_z <= pos_z;
    end
  end

  // a first slice measures against itself
  always_comb begin
    if (first_slice) begin
      dx_next = '0;
      dy_next = '0;
      dz_next = '0;
    end else begin
      dx_next = DW'(pos_x) - DW'(ref_x);
      dy_next = DW'(pos_y) - DW'(ref_y);
      dz_next = DW'(pos_z) - DW'(ref_z);
    end
  end

  assign nx = (2*CW+1)'(p0) - (2*CW+1)'(p1);
  assign ny = (2*CW+1)'(p2) - (2*CW+1)'(p3);
  assign nz = (2*CW+1)'(p4) - (2*CW+1)'(p5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      o_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0.rejected   <= !geometry_valid;
      s0.degenerate <= 1'b0;
      s0.neg        <= '0;
      s0.dx         <= dx_next;
      s0.dy         <= dy_next;
      s0.dz         <= dz_next;
      rx <= row_x;
      ry <= row_y;
      rz <= row_z;
      cx <= col_x;
      cy <= col_y;
      cz <= col_z;

      s1 <= s0;
      p0 <= ry * cz;
      p1 <= rz * cy;
      p2 <= rz * cx;
      p3 <= rx * cz;
      p4 <= rx * cy;
      p5 <= ry * cx;

      s2.rejected   <= s1.rejected;
      s2.degenerate <= s1.degenerate;
      s2.neg        <= {nz[2*CW], ny[2*CW], nx[2*CW]};
      s2.dx         <= s1.dx;
      s2.dy         <= s1.dy;
      s2.dz         <= s1.dz;
      mag2[0] <= nx[2*CW] ? MW'(-nx) : MW'(nx);
      mag2[1] <= ny[2*CW] ? MW'(-ny) : MW'(ny);
      mag2[2] <= nz[2*CW] ? MW'(-nz) : MW'(nz);

      s3.rejected   <= s2.rejected;
      s3.degenerate <= (mag2 == '0);
      s3.neg        <= s2.neg;
      s3.dx         <= s2.dx;
      s3.dy         <= s2.dy;
      s3.dz         <= s2.dz;
      mag3 <= mag2;
      sq0  <= N2W'(mag2[0] * mag2[0]);
      sq1  <= N2W'(mag2[1] * mag2[1]);
      sq2  <= N2W'(mag2[2] * mag2[2]);

      o_side <= s3;
      o_mag  <= mag3;
      o_n2   <= sq0 + sq1 + sq2;
    end
  end

endmodule

/* design/sdn_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module sdn_isqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    i_valid,
  input  sdn_pkg::side_t          i_side,
  input  logic [sdn_pkg::N2W-1:0] i_n2,
  input  sdn_pkg::mag3_t          i_mag,
  output logic                    o_valid,
  output sdn_pkg::side_t          o_side,
  output logic [sdn_pkg::LW-1:0]  o_len,
  output sdn_pkg::mag3_t          o_mag
);
  import sdn_pkg::*;

  localparam int RW = LW + 2;

  logic           v   [0:LW];
  side_t          sd  [0:LW];
  logic [N2W-1:0] n2  [0:LW];
  mag3_t          mg  [0:LW];
  logic [RW-1:0]  rem [0:LW];
  logic [LW-1:0]  root[0:LW];

  assign v[0]    = i_valid;
  assign sd[0]   = i_side;
  assign n2[0]   = i_n2;
  assign mg[0]   = i_mag;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar s = 0; s < LW; s++) begin : g_stage
    localparam int K = LW - 1 - s;
    logic [RW+1:0] shifted;
    logic [RW+1:0] trial;
    logic          take;

    assign shifted = {rem[s], n2[s][2*K+1 -: 2]};
    assign trial   = (RW+2)'({root[s], 2'b01});
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[s+1] <= sd[s];
        n2[s+1] <= n2[s];
        mg[s+1] <= mg[s];
        if (take) begin
          rem[s+1]  <= RW'(shifted - trial);
          root[s+1] <= {root[s][LW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= RW'(shifted);
          root[s+1] <= {root[s][LW-2:0], 1'b0};
        end
      end
    end
  end

  assign o_valid = v[LW];
  assign o_side  = sd[LW];
  assign o_len   = root[LW];
  assign o_mag   = mg[LW];

endmodule

/* design/sdn_udiv.sv */
// Pipelined restoring dividers forming the three rounded unit normal components.
module sdn_udiv (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   i_valid,
  input  sdn_pkg::side_t         i_side,
  input  logic [sdn_pkg::LW-1:0] i_len,
  input  sdn_pkg::mag3_t         i_mag,
  output logic                   o_valid,
  output sdn_pkg::side_t         o_side,
  output sdn_pkg::q3_t           o_q
);
  import sdn_pkg::*;

  logic            v   [0:QW];
  side_t           sd  [0:QW];
  logic [LW-1:0]   len [0:QW];
  logic [2:0][QW-1:0] nlo [0:QW];
  logic [2:0][LW-1:0] r   [0:QW];
  q3_t             q   [0:QW];

  // numerator = magnitude scaled by 2^UNIT_BITS plus half the divisor
  for (genvar l = 0; l < 3; l++) begin : g_num
    logic [NUMW-1:0] num;
    assign num       = {1'b0, i_mag[l], {UNIT_BITS{1'b0}}} + NUMW'(i_len >> 1);
    assign nlo[0][l] = num[QW-1:0];
    assign r[0][l]   = num[NUMW-1:QW];
  end

  assign v[0]   = i_valid;
  assign sd[0]  = i_side;
  assign len[0] = i_len;
  assign q[0]   = '0;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [LW:0] shifted;
      logic        take;

      assign shifted = {r[s][l], nlo[s][l][K]};
      assign take    = shifted >= {1'b0, len[s]};

      always_ff @(posedge clk) begin
        if (adv) begin
          nlo[s+1][l] <= nlo[s][l];
          q[s+1][l]   <= {q[s][l][QW-2:0], take};
          r[s+1][l]   <= take ? LW'(shifted - {1'b0, len[s]}) : LW'(shifted);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[s+1]  <= sd[s];
        len[s+1] <= len[s];
      end
    end
  end

  assign o_valid = v[QW];
  assign o_side  = sd[QW];
  assign o_q     = q[QW];

endmodule

/* design/sdn_dot.sv */
// Dot product of difference and unit normal, rounding, saturation and output register.
module sdn_dot (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  i_valid,
  input  sdn_pkg::side_t        i_side,
  input  sdn_pkg::q3_t          i_q,
  output logic                  o_valid,
  output logic signed [31:0]    distance,
  output logic                  degenerate_normal,
  output logic                  input_rejected
);
  import sdn_pkg::*;

  localparam int HW = DW - SPLIT;
  localparam logic signed [TW-1:0] RND_HALF = TW'(1) << (UNIT_BITS - 1);
  localparam logic signed [TW-1:0] PMAX = (TW'(1) << (PW - 1)) - TW'(1);
  localparam logic signed [TW-1:0] PMIN = -PMAX - TW'(1);

  logic                 va, vb, vc;
  logic                 rej_a, rej_b, rej_c, deg_a, deg_b, deg_c;
  diff_t                d   [3];
  logic signed [QW:0]   u   [3];
  logic signed [HW+QW:0]    ph [3];
  logic signed [SPLIT+QW+1:0] pl [3];
  logic signed [TW-1:0] lane [3];
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] shifted;
  logic signed [TW-1:0] clipped;

  assign d[0] = i_side.dx;
  assign d[1] = i_side.dy;
  assign d[2] = i_side.dz;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [HW-1:0]  dh;
    logic signed [SPLIT:0] dl;

    assign u[l] = i_side.neg[l] ? -$signed({1'b0, i_q[l]}) : $signed({1'b0, i_q[l]});
    assign dh   = d[l][DW-1:SPLIT];
    assign dl   = $signed({1'b0, d[l][SPLIT-1:0]});

    always_ff @(posedge clk) begin
      if (adv) begin
        ph[l]   <= dh * u[l];
        pl[l]   <= dl * u[l];
        lane[l] <= (TW'(ph[l]) <<< SPLIT) + TW'(pl[l]);
      end
    end
  end

  // ties round toward plus infinity
  assign shifted = (total + RND_HALF) >>> UNIT_BITS;

  always_comb begin
    if (rej_c || deg_c) begin
      clipped = '0;
    end else if (shifted > PMAX) begin
      clipped = PMAX;
    end else if (shifted < PMIN) begin
      clipped = PMIN;
    end else begin
      clipped = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      va <= i_valid;
      vb <= va;
      vc <= vb;
      o_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej_a <= i_side.rejected;
      deg_a <= i_side.degenerate;
      rej_b <= rej_a;
      deg_b <= deg_a;
      rej_c <= rej_b;
      deg_c <= deg_b;
      total <= lane[0] + lane[1] + lane[2];
      distance          <= clipped[PW-1:0];
      degenerate_normal <= deg_c && !rej_c;
      input_rejected    <= rej_c;
    end
  end

endmodule

/* design/sdn_checker.sv */
// Port-level checks for the slice distance pipeline, bound to the top level.
module sdn_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] distance,
  input logic               degenerate_normal,
  input logic               input_rejected
);

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(degenerate_normal && input_rejected))
    else $error("both result flags set");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (degenerate_normal || input_rejected) |-> distance == 32'sd0)
    else $error("flagged result with nonzero distance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("stalled result changed");

endmodule

bind slice_distance_along_normal_top sdn_checker u_sdn_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready,
  .distance, .degenerate_normal, .input_rejected
);
